>>> src/utf8vd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8vd_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned STATUS_W = 4;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_MISS_CONT = 4'd2;
    localparam logic [STATUS_W-1:0] ST_OVERLONG  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SURROGATE = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NONCHAR   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ABOVE_MAX = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 4'd7;
    localparam logic [STATUS_W-1:0] ST_END_ERR   = 4'd8;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [CP_W-1:0]     codepoint;
        logic [STATUS_W-1:0] status;
        logic                end_of_buffer;
    } out_word_t;

endpackage

`default_nettype wire

>>> src/utf8vd_apb.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_apb (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [utf8vd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [utf8vd_pkg::PDATA_W-1:0] pwdata,
    output logic      [utf8vd_pkg::PDATA_W-1:0] prdata,
    output logic                                pready,
    output logic                                verify_only
);

    logic verify_only_reg;
    logic verify_only_next;
    logic sel_vo;

    // registers sit on 4-byte words; only word 0 exists
    assign sel_vo = (paddr[utf8vd_pkg::PADDR_W-1] == 1'b0);

    always_comb
    begin
        verify_only_next = verify_only_reg;
        if (psel && penable && pwrite && sel_vo)
        begin
            verify_only_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verify_only_reg <= 1'b0;
        end
        else
        begin
            verify_only_reg <= verify_only_next;
        end
    end

    assign prdata      = sel_vo ? {{(utf8vd_pkg::PDATA_W-1){1'b0}}, verify_only_reg}
                                : '0;
    assign pready      = 1'b1;
    assign verify_only = verify_only_reg;

endmodule

`default_nettype wire

>>> src/utf8vd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_decode (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 verify_only,
    input  wire utf8vd_pkg::in_word_t in_word,
    input  wire logic                 fire,
    output logic                      emit,
    output utf8vd_pkg::out_word_t     result
);

    logic [7:0]                     lead_reg,  lead_next;
    logic [7:0]                     sec_reg,   sec_next;
    logic [utf8vd_pkg::CP_W-1:0]    acc_reg,   acc_next;
    logic [1:0]                     left_reg,  left_next;
    logic [utf8vd_pkg::STATUS_W-1:0] pend_reg, pend_next;
    logic                           drop_reg,  drop_next;

    logic [7:0]                      b;
    logic                            last;
    logic [utf8vd_pkg::STATUS_W-1:0] err;
    logic                            done;
    logic [2:0]                      seq_len;
    logic                            is_second;

    function automatic logic [utf8vd_pkg::STATUS_W-1:0] final_checks(
        input logic [7:0] lead,
        input logic [7:0] sec,
        input logic [7:0] fin
    );
        logic [utf8vd_pkg::STATUS_W-1:0] r;
        r = utf8vd_pkg::ST_OK;
        if (lead >= 8'hF0)
        begin
            if (lead == 8'hF0 && sec[7:4] == 4'h8)
                r = utf8vd_pkg::ST_OVERLONG;
            else if ((lead == 8'hF4 && sec > 8'h8F) || lead > 8'hF4)
                r = utf8vd_pkg::ST_ABOVE_MAX;
        end
        else if (lead >= 8'hE0)
        begin
            if (lead == 8'hE0 && sec[7:5] == 3'b100)
                r = utf8vd_pkg::ST_OVERLONG;
            else if (lead == 8'hED && sec[7:5] == 3'b101)
                r = utf8vd_pkg::ST_SURROGATE;
            else if (lead == 8'hEF)
            begin
                if (sec == 8'hBF && (fin & 8'hFE) == 8'hBE)
                    r = utf8vd_pkg::ST_NONCHAR;
                else if (sec == 8'hB7 && fin >= 8'h90 && fin <= 8'hAF)
                    r = utf8vd_pkg::ST_NONCHAR;
            end
        end
        return r;
    endfunction

    assign b    = in_word.data_byte;
    assign last = in_word.last_byte;

    always_comb
    begin
        if (lead_reg >= 8'hF0)
            seq_len = 3'd4;
        else if (lead_reg >= 8'hE0)
            seq_len = 3'd3;
        else
            seq_len = 3'd2;
    end

    assign is_second = ((seq_len - {1'b0, left_reg}) == 3'd1);

    always_comb
    begin
        lead_next = lead_reg;
        sec_next  = sec_reg;
        acc_next  = acc_reg;
        left_next = left_reg;
        pend_next = pend_reg;
        drop_next = drop_reg;
        err       = utf8vd_pkg::ST_OK;
        done      = 1'b0;
        emit      = 1'b0;
        result    = '0;

        if (drop_reg)
        begin
            if (last)
            begin
                emit                 = 1'b1;
                result.status        = verify_only ? pend_reg : utf8vd_pkg::ST_END_ERR;
                result.end_of_buffer = 1'b1;
                left_next            = 2'd0;
                pend_next            = utf8vd_pkg::ST_OK;
                drop_next            = 1'b0;
            end
        end
        else
        begin
            if (left_reg == 2'd0)
            begin
                lead_next = b;
                if (b < 8'h80)
                begin
                    acc_next = {{(utf8vd_pkg::CP_W-8){1'b0}}, b};
                    done     = 1'b1;
                end
                else if (b >= 8'hC2 && b <= 8'hDF)
                begin
                    acc_next  = {{(utf8vd_pkg::CP_W-5){1'b0}}, b[4:0]};
                    left_next = 2'd1;
                end
                else if (b >= 8'hE0 && b <= 8'hEF)
                begin
                    acc_next  = {{(utf8vd_pkg::CP_W-4){1'b0}}, b[3:0]};
                    left_next = 2'd2;
                end
                else if (b >= 8'hF0 && b <= 8'hF7)
                begin
                    acc_next  = {{(utf8vd_pkg::CP_W-3){1'b0}}, b[2:0]};
                    left_next = 2'd3;
                end
                else
                begin
                    err = utf8vd_pkg::ST_BAD_LEAD;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                err = utf8vd_pkg::ST_MISS_CONT;
            end
            else
            begin
                if (is_second)
                    sec_next = b;
                acc_next  = {acc_reg[utf8vd_pkg::CP_W-7:0], b[5:0]};
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd1)
                begin
                    err  = final_checks(lead_reg, sec_next, b);
                    done = (err == utf8vd_pkg::ST_OK);
                end
            end

            if (err == utf8vd_pkg::ST_OK && !done && left_next != 2'd0 && last)
                err = utf8vd_pkg::ST_TRUNCATED;

            if (err != utf8vd_pkg::ST_OK)
            begin
                left_next     = 2'd0;
                result.status = err;
                if (last)
                begin
                    emit                 = 1'b1;
                    result.end_of_buffer = 1'b1;
                end
                else
                begin
                    pend_next = err;
                    drop_next = 1'b1;
                    emit      = !verify_only;
                end
            end
            else if (done)
            begin
                result.end_of_buffer = last;
                if (verify_only)
                begin
                    emit = last;
                end
                else
                begin
                    emit             = 1'b1;
                    result.codepoint = acc_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            sec_reg  <= '0;
            acc_reg  <= '0;
            left_reg <= '0;
            pend_reg <= utf8vd_pkg::ST_OK;
            drop_reg <= 1'b0;
        end
        else if (fire)
        begin
            lead_reg <= lead_next;
            sec_reg  <= sec_next;
            acc_reg  <= acc_next;
            left_reg <= left_next;
            pend_reg <= pend_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

>>> src/utf8_validating_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 validating decoder.
// Input channel: in_valid/in_stall carry one word per byte (data_byte plus
// last_byte marking the end of a buffer). Output channel: out_valid/out_stall
// carry result words (codepoint, status, end_of_buffer). A byte yields zero
// or one result word.
// Throughput: one byte per cycle while in_stall is low; nothing iterates. A byte
// accepted into the input register is decoded from there, and its result is
// written to the output register and offered on out_valid from then on.
// The input register feeds the decoder state and the output register; a byte
// that gives no result passes even while the output is stalled, one that does
// waits in the input register until the output register is free, and in_stall
// rises only then.
// Reset clears the decoder state, both valid flags and verify_only; the block
// then expects a lead byte.
// verify_only is at APB address 0, bit 0; write it only while idle.

module utf8_validating_decoder_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [utf8vd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [utf8vd_pkg::PDATA_W-1:0] pwdata,
    output logic      [utf8vd_pkg::PDATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire utf8vd_pkg::in_word_t           in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output utf8vd_pkg::out_word_t               out_data
);

    logic                  verify_only;
    logic                  in_vld_reg, in_vld_next;
    utf8vd_pkg::in_word_t  in_word_reg;
    logic                  out_vld_reg, out_vld_next;
    utf8vd_pkg::out_word_t out_word_reg;
    logic                  emit;
    utf8vd_pkg::out_word_t result;
    logic                  advance;

    utf8vd_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .verify_only (verify_only)
    );

    utf8vd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .verify_only (verify_only),
        .in_word     (in_word_reg),
        .fire        (advance),
        .emit        (emit),
        .result      (result)
    );

    assign advance  = in_vld_reg && (!emit || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    always_comb
    begin
        in_vld_next = in_stall ? in_vld_reg : in_valid;
        if (advance && emit)
            out_vld_next = 1'b1;
        else
            out_vld_next = out_vld_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_data;
        if (advance && emit)
            out_word_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

endmodule

`default_nettype wire

>>> src/utf8vd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8vd_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire utf8vd_pkg::out_word_t out_data
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_err_no_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != utf8vd_pkg::ST_OK |-> out_data.codepoint == '0)
        else $error("codepoint set on error word");

    a_end_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == utf8vd_pkg::ST_END_ERR
                      || out_data.status == utf8vd_pkg::ST_TRUNCATED)
        |-> out_data.end_of_buffer)
        else $error("end/truncated status without end_of_buffer");

    a_cp_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == utf8vd_pkg::ST_OK
        |-> out_data.codepoint <= utf8vd_pkg::CP_MAX
            && (out_data.codepoint < 21'hD800 || out_data.codepoint > 21'hDFFF))
        else $error("illegal codepoint delivered");

endmodule

bind utf8_validating_decoder_unit utf8vd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> test/utf8_validating_decoder_unit_test.sv
`timescale 1ns / 1ps

module utf8_validating_decoder_unit_test;

    localparam logic [utf8vd_pkg::PADDR_W-1:0] VERIFY_ONLY_ADDR = '0;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [utf8vd_pkg::PADDR_W-1:0]    paddr = '0;
    logic [utf8vd_pkg::PDATA_W-1:0]    pwdata = '0;
    logic [utf8vd_pkg::PDATA_W-1:0]    prdata;
    logic                              pready;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    utf8vd_pkg::in_word_t              in_data = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    utf8vd_pkg::out_word_t             out_data;

    utf8_validating_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    utf8vd_pkg::in_word_t  pending_bytes[$];
    utf8vd_pkg::out_word_t expected_words[$];
    logic [7:0]            staged[$];
    int                    queued = 0;
    int                    fails = 0;
    int unsigned           cyc = 0;
    utf8vd_pkg::out_word_t want;
    utf8vd_pkg::out_word_t decoded;

    // decoder state mirror
    logic [7:0]                      seq_lead = '0;
    logic [7:0]                      seq_second = '0;
    logic [utf8vd_pkg::CP_W-1:0]     cp_accum = '0;
    logic [1:0]                      conts_left = '0;
    logic [utf8vd_pkg::STATUS_W-1:0] held_err = utf8vd_pkg::ST_OK;
    logic                            dropping = 1'b0;
    logic                            vo_mode = 1'b0;

    wire quiet = (cyc % 1000) >= 700;

    always @(posedge clk)
        cyc <= cyc + 1;

    function automatic void close_buffer();
        conts_left = '0;
        held_err   = utf8vd_pkg::ST_OK;
        dropping   = 1'b0;
    endfunction

    function automatic bit decode_byte(input utf8vd_pkg::in_word_t w,
                                       output utf8vd_pkg::out_word_t r);
        logic [7:0]                      b;
        logic                            last;
        logic [utf8vd_pkg::STATUS_W-1:0] err;
        bit                              done;
        int                              len;
        b    = w.data_byte;
        last = w.last_byte;
        err  = utf8vd_pkg::ST_OK;
        done = 1'b0;
        r    = '0;
        if (dropping)
        begin
            if (!last)
                return 1'b0;
            r.status        = vo_mode ? held_err : utf8vd_pkg::ST_END_ERR;
            r.end_of_buffer = 1'b1;
            close_buffer();
            return 1'b1;
        end
        if (conts_left == 0)
        begin
            seq_lead = b;
            if (b < 8'h80)
            begin
                cp_accum = utf8vd_pkg::CP_W'(b);
                done     = 1'b1;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                cp_accum   = utf8vd_pkg::CP_W'(b[4:0]);
                conts_left = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                cp_accum   = utf8vd_pkg::CP_W'(b[3:0]);
                conts_left = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF7)
            begin
                cp_accum   = utf8vd_pkg::CP_W'(b[2:0]);
                conts_left = 2'd3;
            end
            else
                err = utf8vd_pkg::ST_BAD_LEAD;
        end
        else if (b[7:6] != 2'b10)
            err = utf8vd_pkg::ST_MISS_CONT;
        else
        begin
            len = (seq_lead >= 8'hF0) ? 4 : (seq_lead >= 8'hE0) ? 3 : 2;
            if (len - int'(conts_left) == 1)
                seq_second = b;
            cp_accum   = {cp_accum[utf8vd_pkg::CP_W-7:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 0)
            begin
                if (len == 3)
                begin
                    if (seq_lead == 8'hE0 && seq_second[7:5] == 3'b100)
                        err = utf8vd_pkg::ST_OVERLONG;
                    else if (seq_lead == 8'hED && seq_second[7:5] == 3'b101)
                        err = utf8vd_pkg::ST_SURROGATE;
                    else if (seq_lead == 8'hEF && seq_second == 8'hBF && b[7:1] == 7'h5F)
                        err = utf8vd_pkg::ST_NONCHAR;
                    else if (seq_lead == 8'hEF && seq_second == 8'hB7
                             && b >= 8'h90 && b <= 8'hAF)
                        err = utf8vd_pkg::ST_NONCHAR;
                end
                else if (len == 4)
                begin
                    if (seq_lead == 8'hF0 && seq_second[7:4] == 4'h8)
                        err = utf8vd_pkg::ST_OVERLONG;
                    else if ((seq_lead == 8'hF4 && seq_second > 8'h8F) || seq_lead > 8'hF4)
                        err = utf8vd_pkg::ST_ABOVE_MAX;
                end
                done = (err == utf8vd_pkg::ST_OK);
            end
        end
        if (err == utf8vd_pkg::ST_OK && !done && conts_left != 0 && last)
            err = utf8vd_pkg::ST_TRUNCATED;
        if (err != utf8vd_pkg::ST_OK)
        begin
            conts_left = '0;
            if (last)
            begin
                close_buffer();
                r.status        = err;
                r.end_of_buffer = 1'b1;
                return 1'b1;
            end
            held_err = err;
            dropping = 1'b1;
            if (vo_mode)
                return 1'b0;
            r.status = err;
            return 1'b1;
        end
        if (done)
        begin
            if (last)
                close_buffer();
            if (vo_mode)
            begin
                if (!last)
                    return 1'b0;
                r.end_of_buffer = 1'b1;
                return 1'b1;
            end
            r.codepoint     = cp_accum;
            r.end_of_buffer = last;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (decode_byte(in_data, decoded))
                    expected_words.push_back(decoded);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: codepoint %h status %0d end %0d",
                           out_data.codepoint, out_data.status, out_data.end_of_buffer);
                    fails++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.codepoint !== want.codepoint)
                    begin
                        $error("codepoint: expected %h, got %h", want.codepoint,
                               out_data.codepoint);
                        fails++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fails++;
                    end
                    if (out_data.end_of_buffer !== want.end_of_buffer)
                    begin
                        $error("end_of_buffer: expected %0d, got %0d", want.end_of_buffer,
                               out_data.end_of_buffer);
                        fails++;
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < 9);
        end
    end

    task automatic set_verify_only(input logic value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERIFY_ONLY_ADDR;
        pwdata  <= utf8vd_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        vo_mode = value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[0] !== value)
        begin
            $error("verify_only: expected %0d, got %0d", value, prdata[0]);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic flush_buffer(input bit close);
        utf8vd_pkg::in_word_t w;
        for (int i = 0; i < staged.size(); i++)
        begin
            w.data_byte = staged[i];
            w.last_byte = close && (i == staged.size() - 1);
            pending_bytes.push_back(w);
        end
        queued += staged.size();
        staged.delete();
    endtask

    task automatic send_bytes(input logic [63:0] v, input int n, input bit close);
        for (int i = n - 1; i >= 0; i--)
            staged.push_back(v[i*8 +: 8]);
        flush_buffer(close);
    endtask

    function automatic void encode(input logic [utf8vd_pkg::CP_W-1:0] cp, input int n);
        case (n)
            1: staged.push_back(cp[7:0]);
            2:
            begin
                staged.push_back({3'b110, cp[10:6]});
                staged.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                staged.push_back({4'b1110, cp[15:12]});
                staged.push_back({2'b10, cp[11:6]});
                staged.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                staged.push_back({5'b11110, cp[20:18]});
                staged.push_back({2'b10, cp[17:12]});
                staged.push_back({2'b10, cp[11:6]});
                staged.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // mostly well-formed buffers, some broken sequences, some raw noise
    task automatic stage_random_buffer();
        int                          nseq;
        int                          kind;
        int                          n;
        int unsigned                 lo;
        int unsigned                 hi;
        logic [utf8vd_pkg::CP_W-1:0] cp;
        logic [7:0]                  b;
        bit                          stop;
        stop = 1'b0;
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 6)) staged.push_back(8'($urandom));
            flush_buffer(1'b1);
            return;
        end
        nseq = $urandom_range(1, 6);
        for (int i = 0; i < nseq && !stop; i++)
        begin
            kind = $urandom_range(0, 99);
            n    = (kind < 80) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            lo   = (n == 1) ? 0 : (n == 2) ? 'h80 : (n == 3) ? 'h800 : 'h10000;
            hi   = (n == 1) ? 'h7F : (n == 2) ? 'h7FF : (n == 3) ? 'hFFFF : 'h10FFFF;
            if ($urandom_range(0, 7) == 0)
                cp = $urandom_range(0, 1) ? utf8vd_pkg::CP_W'(lo) : utf8vd_pkg::CP_W'(hi);
            else
                cp = utf8vd_pkg::CP_W'($urandom_range(lo, hi));
            if (kind < 80)
                encode(cp, n);
            else if (kind < 83)
                encode(utf8vd_pkg::CP_W'($urandom_range(0, lo - 1)), n);
            else if (kind < 86)
                encode(utf8vd_pkg::CP_W'($urandom_range('hD800, 'hDFFF)), 3);
            else if (kind < 88)
                encode(utf8vd_pkg::CP_W'($urandom_range('hFDD0, 'hFDEF)), 3);
            else if (kind < 89)
                encode(utf8vd_pkg::CP_W'($urandom_range('hFFFE, 'hFFFF)), 3);
            else if (kind < 92)
                encode(utf8vd_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
            else if (kind < 95)
            begin
                encode(cp, n);
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                staged[staged.size() - $urandom_range(1, n - 1)] = b;
            end
            else if (kind < 97)
                staged.push_back(8'($urandom));
            else
            begin
                encode(cp, n);
                repeat ($urandom_range(1, n - 1)) void'(staged.pop_back());
                stop = 1'b1;
            end
        end
        flush_buffer(1'b1);
    endtask

    task automatic stage_directed();
        send_bytes(64'h7F_DFBF_F48FBFBF, 7, 1'b1);
        send_bytes(64'h00_FF_80, 3, 1'b1);
        send_bytes(64'hC1_41_00, 3, 1'b1);
        send_bytes(64'hC2_41, 2, 1'b1);
        send_bytes(64'hE0_9F_BF, 3, 1'b1);
        send_bytes(64'hED_A0_80, 3, 1'b1);
        send_bytes(64'hEF_BF_BF, 3, 1'b1);
        send_bytes(64'hF0_8F_BF_BF, 4, 1'b1);
        send_bytes(64'hF5_80_80_80, 4, 1'b1);
        send_bytes(64'hE2_82, 2, 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_verify_only(1'b0);
        stage_directed();
        while (queued < 500)
            stage_random_buffer();
        // leave a drop open across the mode change
        send_bytes(64'hC0, 1, 1'b0);
        settle();

        set_verify_only(1'b1);
        send_bytes(64'h41_42, 2, 1'b1);
        stage_directed();
        while (queued < 1000)
            stage_random_buffer();
        send_bytes(64'hE0_80_80, 3, 1'b0);
        settle();

        set_verify_only(1'b0);
        send_bytes(64'h41, 1, 1'b1);
        while (queued < 1400)
            stage_random_buffer();
        settle();

        set_verify_only(1'b1);
        while (queued < 1550)
            stage_random_buffer();
        settle();

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
